@@ hw/rtl/dcmrpc_pkg.sv @@
`timescale 1ns / 1ps
package dcmrpc_pkg;

  localparam int CountsPerRev = 3000;
  localparam int TickRate     = 10;
  localparam int LimLevel     = 1800;
  localparam int QueueDepth   = 2;

  localparam logic [7:0] M_DISABLE = 8'd0;
  localparam logic [7:0] M_ENABLE  = 8'd1;
  localparam logic [7:0] M_NEWPID  = 8'd2;
  localparam logic [7:0] M_PID     = 8'd3;
  localparam logic [7:0] M_NEWRAMP = 8'd4;
  localparam logic [7:0] M_RAMP    = 8'd5;
  localparam logic [7:0] M_STOP    = 8'd8;
  localparam logic [7:0] M_IDLE    = 8'd255;

  localparam logic [2:0] A_MODE   = 3'd0;
  localparam logic [2:0] A_TARGET = 3'd1;
  localparam logic [2:0] A_TRACK  = 3'd3;
  localparam logic [2:0] A_VREF   = 3'd6;

  localparam logic [1:0] R_PROP  = 2'd0;
  localparam logic [1:0] R_INTEG = 2'd1;
  localparam logic [1:0] R_DERIV = 2'd2;

  typedef struct packed {
    logic               action;
    logic [2:0]         reg_addr;
    logic signed [31:0] write_value;
    logic [11:0]        pos_count;
    logic signed [15:0] rev_count;
  } in_item_t;

  typedef struct packed {
    logic [14:0]        duty_a;
    logic [14:0]        duty_b;
    logic [14:0]        drive_level;
    logic               direction;
    logic               outputs_enabled;
    logic [7:0]         mode;
    logic signed [31:0] velocity;
  } out_item_t;

  // Classified item handed from front to back.
  typedef struct packed {
    logic               is_write;
    logic [2:0]         reg_addr;
    logic signed [31:0] write_value;
    logic signed [29:0] position;
  } work_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

@@ hw/rtl/dcmrpc_front.sv @@
`timescale 1ns / 1ps
module dcmrpc_front
  import dcmrpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_ready,
  output work_t    q_data
);
  localparam int PtrW = $clog2(QueueDepth);

  work_t            mem [QueueDepth];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [PtrW:0]    count;
  logic signed [29:0] pos;
  work_t            w;
  logic             push, pop;

  // position = rev * 3000 + count
  assign pos = 30'(in_data.rev_count * $signed(30'(CountsPerRev)))
             + $signed({18'd0, in_data.pos_count});

  always_comb begin
    w.is_write    = in_data.action;
    w.reg_addr    = in_data.reg_addr;
    w.write_value = in_data.write_value;
    w.position    = pos;
  end

  assign in_ready = (count != (PtrW+1)'(QueueDepth));
  assign q_valid  = (count != '0);
  assign q_data   = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= w;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(QueueDepth-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(QueueDepth-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end
endmodule

@@ hw/rtl/dcmrpc_back.sv @@
`timescale 1ns / 1ps
module dcmrpc_back
  import dcmrpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_val,
  input  logic        q_valid,
  output logic        q_ready,
  input  work_t       q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);
  logic [15:0] kp, ki, kd;
  logic [7:0]  mode_reg;
  logic [15:0] level;
  logic        dir_reg, ramp_dir, running, tracking, pins_on;
  logic [15:0] ramp_target;
  logic signed [31:0] integrator, prev_vel, vref;
  logic signed [29:0] prev_pos;
  logic [14:0] lat_a, lat_b;

  logic [7:0]  mode_n;
  logic [15:0] level_n, target_n;
  logic        dir_n, rdir_n, run_n, track_n, pins_n, latch;
  logic signed [31:0] integ_n, vref_n, vel;
  logic signed [33:0] vdiff;
  logic signed [34:0] err, derr;
  logic signed [35:0] isum;
  logic signed [63:0] s;
  logic signed [32:0] x, xa;
  logic signed [31:0] x6;
  logic signed [17:0] lv, rt;
  logic        nd;
  logic [15:0] nv;
  logic        take;

  assign q_ready = !out_valid || out_ready;
  assign take    = q_valid && q_ready;

  assign vdiff = 34'(q_data.position) - 34'(prev_pos);
  assign vel   = sat32(64'(vdiff) * 64'(TickRate));
  assign err   = 35'(vel) - 35'(vref);
  assign derr  = 35'(vel) - 35'(prev_vel);
  assign isum  = 36'(integrator) + 36'(err);
  assign s = $signed({48'd0, ki}) * 64'(isum) + $signed({48'd0, kp}) * 64'(err)
           + $signed({48'd0, kd}) * 64'(derr);
  assign x  = 33'(q_data.write_value);
  assign xa = x[32] ? -x : x;
  assign x6 = tracking ? sat32(64'(q_data.write_value) + 64'sd600) : q_data.write_value;
  assign lv = $signed({2'b0, level});
  assign rt = $signed({2'b0, ramp_target});

  always_comb begin
    mode_n = mode_reg; level_n = level; target_n = ramp_target;
    dir_n = dir_reg; rdir_n = ramp_dir; run_n = running; track_n = tracking;
    pins_n = pins_on; integ_n = integrator; vref_n = vref; latch = 1'b0;
    nd = 1'b0; nv = '0;
    if (q_data.is_write) begin
      unique case (q_data.reg_addr)
        A_MODE: mode_n = q_data.write_value[7:0];
        A_TARGET: begin
          rdir_n   = x[32];
          target_n = (xa > 33'sd32767) ? 16'd32767 : xa[15:0];
          mode_n   = M_NEWRAMP;
        end
        A_TRACK: begin
          if (q_data.write_value == 0) begin
            track_n = 1'b0;
            if (vref > 0 && vref < 1200) begin
              mode_n = M_STOP; vref_n = '0;
            end
          end else begin
            track_n = 1'b1;
            if (vref == 0) begin
              vref_n = 32'sd600; mode_n = M_PID;
            end
          end
        end
        A_VREF: begin
          if (x6 == 0) begin
            if (vref > -19200 && vref < 19200) mode_n = M_STOP;
            else begin
              target_n = '0; rdir_n = dir_reg; mode_n = M_NEWRAMP;
            end
          end else mode_n = M_PID;
          vref_n = x6;
        end
        default: ;
      endcase
    end else begin
      unique case (mode_reg)
        M_DISABLE: begin pins_n = 1'b0; mode_n = M_IDLE; level_n = '0; end
        M_ENABLE:  begin pins_n = 1'b1; mode_n = M_IDLE; level_n = '0; end
        M_NEWRAMP: begin
          if (!running) begin run_n = 1'b1; level_n = '0; end
          mode_n = M_RAMP;
        end
        M_RAMP: begin
          latch = 1'b1;
          if (ramp_dir == dir_reg) begin
            if (lv - rt > 18'sd5) level_n = (level < 16'd10) ? '0 : level - 16'd10;
            else if (rt - lv > 18'sd5)
              level_n = (level > 16'd32757) ? 16'd32767 : level + 16'd10;
            else level_n = ramp_target;
          end else begin
            if (level > 16'd5) level_n = (level < 16'd10) ? '0 : level - 16'd10;
            else begin level_n = '0; dir_n = ramp_dir; end
          end
        end
        M_NEWPID: begin
          integ_n = '0; level_n = '0; run_n = 1'b1; mode_n = M_PID;
        end
        M_PID: begin
          latch = 1'b1;
          priority if (s < -64'(LimLevel * 4096)) begin
            nv = 16'(LimLevel); nd = 1'b0;
          end else if (s < 0) begin
            integ_n = sat32(64'(isum)); nv = 16'((-s) >>> 12); nd = 1'b0;
          end else if (s < 64'(LimLevel * 4096)) begin
            integ_n = sat32(64'(isum)); nv = 16'(s >>> 12); nd = 1'b1;
          end else begin
            nv = 16'(LimLevel); nd = 1'b1;
          end
          if (dir_reg != nd && vel != 0) level_n = 16'd50;
          else begin level_n = nv; dir_n = nd; end
        end
        M_STOP: begin
          integ_n = '0; level_n = '0; latch = 1'b1; mode_n = M_IDLE;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_data.duty_a          = lat_a;
    out_data.duty_b          = lat_b;
    out_data.drive_level     = level[14:0];
    out_data.direction       = dir_reg;
    out_data.outputs_enabled = pins_on;
    out_data.mode            = mode_reg;
    out_data.velocity        = prev_vel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kp <= 16'd614; ki <= 16'd82; kd <= 16'd41;
      mode_reg <= M_IDLE; level <= '0; dir_reg <= 1'b1; ramp_target <= '0;
      ramp_dir <= 1'b0; running <= 1'b0; integrator <= '0; prev_vel <= '0;
      prev_pos <= '0; vref <= '0; tracking <= 1'b0; pins_on <= 1'b1;
      lat_a <= '0; lat_b <= '0; out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          R_PROP:  kp <= cfg_val;
          R_INTEG: ki <= cfg_val;
          R_DERIV: kd <= cfg_val;
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (take) begin
        out_valid <= 1'b1;
        mode_reg <= mode_n; level <= level_n; dir_reg <= dir_n;
        ramp_target <= target_n; ramp_dir <= rdir_n; running <= run_n;
        tracking <= track_n; pins_on <= pins_n; integrator <= integ_n;
        vref <= vref_n;
        if (!q_data.is_write) begin
          prev_pos <= q_data.position;
          prev_vel <= vel;
        end
        if (latch) begin
          lat_a <= dir_n ? level_n[14:0] : '0;
          lat_b <= dir_n ? '0 : level_n[14:0];
        end
      end
    end
  end
endmodule

@@ hw/rtl/dc_motor_ramp_pid_controller_unit.sv @@
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// in        in_valid / in_ready       in_data  (in_item_t)
// out       out_valid / out_ready     out_data (out_item_t)
// cfg       cfg_we                    cfg_idx, cfg_data
//
// One transfer in gives one transfer out; a new item is taken every cycle while out_ready holds.
// An item passes through the front queue and then the back output register.
// The back part's PID sum (one 16x36 and two 16x35 products) sets the cycle time.
// rst clears all state to its reset values; gains return to 614, 82, 41.
// A stalled output holds in its register; the two-entry queue keeps taking input until it is full.
module dc_motor_ramp_pid_controller_unit
  import dcmrpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_data
);
  logic  q_valid, q_ready;
  work_t q_data;

  // Front: compute position and queue the classified item.
  dcmrpc_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_data
  );

  // Back: run the mode machine and hold the result.
  dcmrpc_back u_back (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_val(cfg_data),
    .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .out_data
  );

  // Only one bridge side is ever driven: one of the two duties is always zero.
  a_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.duty_a == 15'd0 || out_data.duty_b == 15'd0))
    else $error("both duties non-zero");

  // A stalled result holds until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped");

  // Input stalls only while the queue holds items for the back part.
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_valid)
    else $error("queue full yet empty");
endmodule
